// ----- rtl/core/efd_pkg.sv -----
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants for the escaped serial frame deframer.
// ----------------------------------------------------------------------------
package efd_pkg;

    localparam int MAX_PAYLOAD = 128;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W       = 7;

    localparam logic [7:0] LEN_SKIP_BYTE = 8'hFF;
    localparam logic [7:0] ESC_BYTE      = 8'hFD;
    localparam logic [7:0] ESC_MIN       = 8'h7D;
    localparam logic [7:0] ESC_ADD       = 8'h80;

    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic CFG_HEAD = 1'b0;
    localparam logic CFG_END  = 1'b1;

    typedef enum logic [3:0] {
        PH_HEAD = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_CMD  = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       value;
        logic [15:0]      frame_length;
        logic [IDX_W-1:0] index;
        logic             overflow;
    } rec_t;

endpackage

// ----- rtl/core/efd_parser.sv -----
// ----------------------------------------------------------------------------
// efd_parser
// Frame state machine: consumes one byte per step and produces at most one
// record (header, data byte or frame end).
// ----------------------------------------------------------------------------
module efd_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    head_value,
    input  logic [7:0]    end_value,
    output logic          rec_valid,
    output efd_pkg::rec_t rec
);

    efd_pkg::phase_t             phase_reg, phase_next;
    logic                        len_seen_reg, len_seen_next;
    logic [15:0]                 len_acc_reg, len_acc_next;
    logic [7:0]                  held_reg, held_next;
    logic                        held_valid_reg, held_valid_next;
    logic [efd_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic [efd_pkg::CNT_W-1:0]   pos;

    assign pos = count_reg - efd_pkg::CNT_W'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        len_seen_next   = len_seen_reg;
        len_acc_next    = len_acc_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        rec_valid       = 1'b0;
        rec             = '0;

        unique case (phase_reg)
            efd_pkg::PH_HEAD:
            begin
                if (rx_byte == head_value)
                begin
                    phase_next    = efd_pkg::PH_LEN;
                    len_seen_next = 1'b0;
                end
            end
            efd_pkg::PH_LEN:
            begin
                if (!len_seen_reg)
                begin
                    // A 0xFF in the first length position is a filler byte.
                    if (rx_byte != efd_pkg::LEN_SKIP_BYTE)
                    begin
                        len_acc_next  = {8'h00, rx_byte};
                        len_seen_next = 1'b1;
                    end
                end
                else
                begin
                    len_acc_next  = {len_acc_reg[7:0], rx_byte};
                    len_seen_next = 1'b0;
                    phase_next    = efd_pkg::PH_CMD;
                end
            end
            efd_pkg::PH_CMD:
            begin
                held_next          = '0;
                held_valid_next    = 1'b0;
                count_next         = '0;
                ovf_next           = 1'b0;
                phase_next         = efd_pkg::PH_DATA;
                rec_valid          = 1'b1;
                rec.kind           = efd_pkg::KIND_HDR;
                rec.value          = rx_byte;
                rec.frame_length   = len_acc_reg;
            end
            efd_pkg::PH_DATA:
            begin
                if (rx_byte == end_value)
                begin
                    rec_valid       = 1'b1;
                    rec.kind        = efd_pkg::KIND_END;
                    rec.value       = held_valid_reg ? held_reg : 8'h00;
                    rec.overflow    = ovf_reg;
                    held_next       = '0;
                    held_valid_next = 1'b0;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    phase_next      = efd_pkg::PH_HEAD;
                end
                else if (rx_byte == efd_pkg::ESC_BYTE && held_valid_reg &&
                         held_reg >= efd_pkg::ESC_MIN)
                begin
                    held_next = held_reg + efd_pkg::ESC_ADD;
                end
                else if (count_reg == efd_pkg::CNT_W'(efd_pkg::MAX_PAYLOAD))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    // The previous byte is released once its successor proves
                    // it was not escaped.
                    if (held_valid_reg)
                    begin
                        rec_valid = 1'b1;
                        rec.kind  = efd_pkg::KIND_DATA;
                        rec.value = held_reg;
                        rec.index = efd_pkg::IDX_W'(32'(pos));
                    end
                    held_next       = rx_byte;
                    held_valid_next = 1'b1;
                    count_next      = count_reg + efd_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                phase_next = efd_pkg::PH_HEAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= efd_pkg::PH_HEAD;
            len_seen_reg   <= 1'b0;
            len_acc_reg    <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            len_seen_reg   <= len_seen_next;
            len_acc_reg    <= len_acc_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

// ----- rtl/core/escaped_serial_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// escaped_serial_frame_deframer
// Receive-side parser for head/length/command/payload/end serial frames.
// ----------------------------------------------------------------------------
// Pipeline: a word accepted is held in the input register, and its record
// (if any) is registered in the output register when the parser steps.
// Throughput: one word per cycle unless m_tready stalls the output; the input
// register lets one word be taken while a record waits on the output.
// Reset: rst_n returns the frame state to the head phase, empties both stages
// (valid flags only) and clears the head and end registers to zero.
module escaped_serial_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] value, [23:8] frame_length,
                                    // [30:24] index, [31] overflow
    output logic [1:0]  m_tuser,    // [1:0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    efd_pkg::rec_t out_reg;
    logic [7:0]    head_reg;
    logic [7:0]    end_reg;
    logic          out_free;
    logic          step;
    logic          rec_valid;
    efd_pkg::rec_t rec;

    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            end_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                efd_pkg::CFG_HEAD: head_reg <= cfg_data;
                efd_pkg::CFG_END:  end_reg  <= cfg_data;
                default:           head_reg <= head_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    efd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (in_byte_reg),
        .head_value (head_reg),
        .end_value  (end_reg),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= rec_valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && rec_valid)
        begin
            out_reg <= rec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {out_reg.overflow, out_reg.index, out_reg.frame_length,
                       out_reg.value};

    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == efd_pkg::KIND_HDR || m_tuser == efd_pkg::KIND_DATA ||
                      m_tuser == efd_pkg::KIND_END))
        else $error("record kind out of range");

    a_hdr_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == efd_pkg::KIND_HDR) |-> (m_tdata[31:24] == 8'h00))
        else $error("header record carries index or overflow");

    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == efd_pkg::KIND_DATA) |->
            (m_tdata[23:8] == 16'h0000 && !m_tdata[31]))
        else $error("data record carries length or overflow");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while both stages are full");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("pending record lost");

endmodule
